// ===== rtl/mctt_pkg.sv =====
// Shared types and codes of the multi-channel tick timer and PWM core.
package mctt_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// Channel modes
	localparam logic [1:0] MODE_ONCE   = 2'd0;
	localparam logic [1:0] MODE_REPEAT = 2'd1;
	localparam logic [1:0] MODE_PWM    = 2'd2;

	// Fixed widths of the transaction fields
	localparam int unsigned FIELD_COUNT_W = 32;
	localparam int unsigned MASK_W        = 8;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [2:0]               channel;
		logic [1:0]               mode;
		logic [FIELD_COUNT_W-1:0] reload_count;
		logic [FIELD_COUNT_W-1:0] duty_count;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] expired_mask;
		logic [MASK_W-1:0] pwm_level_mask;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} fsm_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture the incoming transaction
		logic step;     // process one channel of a tick sweep
		logic apply;    // carry out a start or stop request
		logic publish;  // move the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_tick;
	} dp_sts_t;

endpackage

// ===== rtl/multi_channel_tick_timer_pwm_core.sv =====
// Top level of the multi-channel tick timer and PWM core.
// A bank of CHANNELS down-counting timers, each run as one-shot, repeat or PWM.
// Every request transaction (tick, start or stop) yields exactly one result
// transaction carrying the expiry mask of that tick and the PWM output levels
// after the request. A tick sweeps the bank through one shared decrement and
// compare unit, one channel per cycle; a tick runs through capture, CHANNELS
// sweep steps and hand-over to the result register, while start and stop
// run through capture, an apply step and hand-over. The result register lets
// the next request be taken while an earlier result still waits; if that
// result is still stalled when the next one is ready, the core holds until
// the output side takes it. Reload and duty counts keep their low COUNT_WIDTH
// bits, starts and stops addressed beyond the bank are dropped, and channels
// above the eighth count normally but do not appear in the 8-bit result masks.
module multi_channel_tick_timer_pwm_core
	import mctt_pkg::*;
#(
	parameter int unsigned CHANNELS    = 8,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [IDX_W-1:0] idx;

	// Sequence the capture, sweep and publish steps of each transaction
	mctt_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.idx       (idx),
		.sts       (sts)
	);

	// Hold the channel state, advance one channel per sweep step, drive the result
	mctt_dp #(
		.CHANNELS    (CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.idx    (idx),
		.sts    (sts)
	);

endmodule

// ===== rtl/mctt_ctrl.sv =====
// Controller state machine of the multi-channel tick timer and PWM core.
module mctt_ctrl
	import mctt_pkg::*;
#(
	parameter int unsigned CHANNELS = 8,
	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             res_valid,
	input  logic             res_stall,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] idx,
	input  dp_sts_t          sts
);

	fsm_state_t       state_q;
	fsm_state_t       state_d;
	logic [IDX_W-1:0] idx_q;
	logic             idx_last;
	logic             res_valid_q;
	logic             out_free;

	assign idx_last = (idx_q == IDX_W'(CHANNELS - 1));
	assign out_free = !res_valid_q || !res_stall;
	assign idx      = idx_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (cmd.publish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.is_tick) begin
					cmd.step = 1'b1;
					if (idx_last) begin
						state_d = ST_FINISH;
					end
				end else begin
					cmd.apply = 1'b1;
					state_d   = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_RUN))
		else $error("accepted transaction did not start processing");

	a_publish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!res_valid_q || !res_stall))
		else $error("result published over an untaken result");

	a_idle_sweep_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("sweep index not at first channel while idle");

	a_step_apply_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.apply))
		else $error("tick sweep and start/stop issued together");

endmodule

// ===== rtl/mctt_dp.sv =====
// Datapath of the multi-channel tick timer and PWM core: channel state and result register.
module mctt_dp
	import mctt_pkg::*;
#(
	parameter int unsigned CHANNELS    = 8,
	parameter int unsigned COUNT_WIDTH = 32,
	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	output res_t             res,
	input  dp_cmd_t          cmd,
	input  logic [IDX_W-1:0] idx,
	output dp_sts_t          sts
);

	localparam int unsigned PAD_W = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

	logic [COUNT_WIDTH-1:0] remaining_q [CHANNELS];
	logic [COUNT_WIDTH-1:0] reload_q    [CHANNELS];
	logic [COUNT_WIDTH-1:0] duty_q      [CHANNELS];
	logic [1:0]             mode_q      [CHANNELS];
	logic [CHANNELS-1:0]    level_q;
	logic [CHANNELS-1:0]    expired_q;
	req_t                   item_q;
	res_t                   res_q;

	logic                   is_start;
	logic                   is_stop;
	logic [CHANNELS-1:0]    hit;
	logic [COUNT_WIDTH-1:0] load_reload;
	logic [COUNT_WIDTH-1:0] load_duty;
	logic [COUNT_WIDTH-1:0] rem_cur;
	logic [COUNT_WIDTH-1:0] rem_dec;
	logic [COUNT_WIDTH-1:0] rem_nxt;
	logic                   lvl_nxt;
	logic                   exp_nxt;
	logic [PAD_W-1:0]       expired_pad;
	logic [PAD_W-1:0]       level_pad;

	assign sts.is_tick = (item_q.req_type == REQ_TICK);
	assign is_start    = (item_q.req_type == REQ_START);
	assign is_stop     = (item_q.req_type == REQ_STOP);
	assign load_reload = COUNT_WIDTH'(item_q.reload_count);
	assign load_duty   = COUNT_WIDTH'(item_q.duty_count);

	// Decode the addressed channel; indices past the bank match nothing
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			hit[c] = (32'(item_q.channel) == 32'(c));
		end
	end

	// Next state of the channel under the sweep index
	always_comb begin
		rem_cur = remaining_q[idx];
		rem_dec = rem_cur - 1'b1;
		rem_nxt = rem_cur;
		lvl_nxt = level_q[idx];
		exp_nxt = 1'b0;
		if (rem_cur != '0) begin
			rem_nxt = rem_dec;
			case (mode_q[idx])
				MODE_ONCE: begin
					exp_nxt = (rem_dec == '0);
				end
				MODE_REPEAT: begin
					if (rem_dec == '0) begin
						rem_nxt = reload_q[idx];
						exp_nxt = 1'b1;
					end
				end
				MODE_PWM: begin
					if (duty_q[idx] != reload_q[idx]) begin
						if (rem_dec == '0) begin
							lvl_nxt = 1'b0;
							rem_nxt = reload_q[idx];
						end
						if (rem_nxt == duty_q[idx]) begin
							lvl_nxt = 1'b1;
						end
					end else if (rem_dec == '0) begin
						rem_nxt = reload_q[idx];
					end
				end
				default: begin
					rem_nxt = rem_dec;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				remaining_q[c] <= '0;
				reload_q[c]    <= '0;
				duty_q[c]      <= '0;
				mode_q[c]      <= MODE_ONCE;
			end
			level_q <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (cmd.step && (idx == IDX_W'(c))) begin
					remaining_q[c] <= rem_nxt;
					level_q[c]     <= lvl_nxt;
				end else if (cmd.apply && hit[c] && is_start) begin
					mode_q[c]      <= item_q.mode;
					reload_q[c]    <= load_reload;
					duty_q[c]      <= load_duty;
					remaining_q[c] <= load_reload;
					level_q[c]     <= 1'b0;
				end else if (cmd.apply && hit[c] && is_stop) begin
					remaining_q[c] <= '0;
				end
			end
		end
	end

	// Transaction hold, expiry collection and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= req;
			expired_q <= '0;
		end else if (cmd.step && exp_nxt) begin
			expired_q[idx] <= 1'b1;
		end
		if (cmd.publish) begin
			res_q.expired_mask   <= sts.is_tick ? expired_pad[MASK_W-1:0] : '0;
			res_q.pwm_level_mask <= level_pad[MASK_W-1:0];
		end
	end

	assign expired_pad = PAD_W'(expired_q);
	assign level_pad   = PAD_W'(level_q);
	assign res         = res_q;

endmodule
